>>> sv/mftt_pkg.sv
// Shared constants and types for the motor feedback turn tracker.
// No dependencies; used by the core and its checker.
`default_nettype none

package mftt_pkg;

  localparam int MOTOR_COUNT_DEF = 4;

  localparam int ID_W     = 11;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int TURN_W   = 32;
  localparam int MIDX_W   = 2;
  localparam int CFG_DW   = 16;
  localparam int CFG_IW   = 1;

  localparam logic [ID_W-1:0]   BASE_ID_RST   = 11'h201;
  localparam logic [WORD_W-1:0] WRAP_THR_RST  = 16'd5460;

  localparam logic [CFG_IW-1:0] CFG_IDX_BASE_ID  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_IDX_WRAP_THR = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   frame_identifier;
    logic [BYTE_W-1:0] payload_byte0;
    logic [BYTE_W-1:0] payload_byte1;
    logic [BYTE_W-1:0] payload_byte2;
    logic [BYTE_W-1:0] payload_byte3;
  } in_word_t;

endpackage

`default_nettype wire

>>> sv/motor_feedback_turn_tracker_core.sv
// Turn tracker core: decodes motor feedback frames and keeps per-motor state.
// Depends on mftt_pkg for widths, reset values and register indexes.
//
// Usage. A word on the input channel is one received frame: its 11-bit
// identifier and the first four payload bytes. Each accepted word gives
// exactly one word on the result channel. A frame whose identifier lies in
// the window of MOTOR_COUNT identifiers starting at the base identifier
// updates that motor's speed, angle and turn count; any other frame gives
// an all-zero result and leaves the state alone.
// A word passes through the input register, then the state update and the
// result register. Throughput is one word per cycle while the receiver
// takes results, set by the single read-modify-write of the per-motor
// registers between the two stages.
// When the receiver stalls, the result register holds its word and the
// input register can still take one further word; the input stalls only
// while both stages are full. Reset clears both stages, all per-motor
// state to zero and the two configuration registers to their defaults.
// The user must write configuration through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module motor_feedback_turn_tracker_core #(
  parameter int MOTOR_COUNT = mftt_pkg::MOTOR_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              cfg_we,
  input  wire logic [mftt_pkg::CFG_IW-1:0]       cfg_index,
  input  wire logic [mftt_pkg::CFG_DW-1:0]       cfg_data,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mftt_pkg::ID_W-1:0]         in_frame_identifier,
  input  wire logic [mftt_pkg::BYTE_W-1:0]       in_payload_byte0,
  input  wire logic [mftt_pkg::BYTE_W-1:0]       in_payload_byte1,
  input  wire logic [mftt_pkg::BYTE_W-1:0]       in_payload_byte2,
  input  wire logic [mftt_pkg::BYTE_W-1:0]       in_payload_byte3,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_matched,
  output logic [mftt_pkg::MIDX_W-1:0]            out_motor_index,
  output logic signed [mftt_pkg::WORD_W-1:0]     out_speed_value,
  output logic [mftt_pkg::WORD_W-1:0]            out_angle_value,
  output logic signed [mftt_pkg::TURN_W-1:0]     out_turn_count
);

  localparam int IDX_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ID_W   = mftt_pkg::ID_W;
  localparam int WORD_W = mftt_pkg::WORD_W;
  localparam int TURN_W = mftt_pkg::TURN_W;
  localparam int MIDX_W = mftt_pkg::MIDX_W;

  logic [ID_W-1:0]   base_id_r;
  logic [WORD_W-1:0] wrap_thr_r;

  logic                 s1_valid_r;
  mftt_pkg::in_word_t   s1_word_r;

  logic [WORD_W-1:0] speed_r [MOTOR_COUNT];
  logic [WORD_W-1:0] angle_r [MOTOR_COUNT];
  logic [TURN_W-1:0] turns_r [MOTOR_COUNT];

  logic                      out_valid_r;
  logic                      out_matched_r;
  logic [MIDX_W-1:0]         out_midx_r;
  logic [WORD_W-1:0]         out_speed_r;
  logic [WORD_W-1:0]         out_angle_r;
  logic [TURN_W-1:0]         out_turns_r;

  logic              s1_move;
  logic [ID_W:0]     offset;
  logic              hit;
  logic [IDX_W-1:0]  midx;
  logic [IDX_W+MIDX_W-1:0] midx_ext;
  logic [WORD_W-1:0] new_speed;
  logic [WORD_W-1:0] new_angle;
  logic signed [WORD_W:0] diff;
  logic signed [WORD_W:0] thr_pos;
  logic signed [WORD_W:0] thr_neg;
  logic [TURN_W-1:0] turns_nxt;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_comb begin
    offset    = {1'b0, s1_word_r.frame_identifier} - {1'b0, base_id_r};
    hit       = !offset[ID_W] && (offset[ID_W-1:0] < ID_W'(MOTOR_COUNT));
    midx      = offset[IDX_W-1:0];
    midx_ext  = {{MIDX_W{1'b0}}, midx};
    new_speed = {s1_word_r.payload_byte2, s1_word_r.payload_byte3};
    new_angle = {s1_word_r.payload_byte0, s1_word_r.payload_byte1};
    diff      = $signed({1'b0, angle_r[midx]}) - $signed({1'b0, new_angle});
    thr_pos   = $signed({1'b0, wrap_thr_r});
    thr_neg   = -thr_pos;
    turns_nxt = turns_r[midx];
    if (diff > thr_pos) begin
      turns_nxt = turns_r[midx] + TURN_W'(1);
    end else if (diff < thr_neg) begin
      turns_nxt = turns_r[midx] - TURN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r  <= mftt_pkg::BASE_ID_RST;
      wrap_thr_r <= mftt_pkg::WRAP_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mftt_pkg::CFG_IDX_BASE_ID:  base_id_r  <= cfg_data[ID_W-1:0];
        mftt_pkg::CFG_IDX_WRAP_THR: wrap_thr_r <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r.frame_identifier <= in_frame_identifier;
      s1_word_r.payload_byte0    <= in_payload_byte0;
      s1_word_r.payload_byte1    <= in_payload_byte1;
      s1_word_r.payload_byte2    <= in_payload_byte2;
      s1_word_r.payload_byte3    <= in_payload_byte3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        speed_r[i] <= '0;
        angle_r[i] <= '0;
        turns_r[i] <= '0;
      end
    end else if (s1_move && hit) begin
      speed_r[midx] <= new_speed;
      angle_r[midx] <= new_angle;
      turns_r[midx] <= turns_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_matched_r <= hit;
      out_midx_r    <= hit ? midx_ext[MIDX_W-1:0] : '0;
      out_speed_r   <= hit ? new_speed : '0;
      out_angle_r   <= hit ? new_angle : '0;
      out_turns_r   <= hit ? turns_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_motor_index = out_midx_r;
  assign out_speed_value = $signed(out_speed_r);
  assign out_angle_value = out_angle_r;
  assign out_turn_count  = $signed(out_turns_r);

endmodule

`default_nettype wire

>>> sv/mftt_checker.sv
// Port-level checker for the turn tracker core, bound to the core module.
// Depends on mftt_pkg for field widths.
`default_nettype none

module mftt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_matched,
  input wire logic [mftt_pkg::MIDX_W-1:0]       out_motor_index,
  input wire logic signed [mftt_pkg::WORD_W-1:0] out_speed_value,
  input wire logic [mftt_pkg::WORD_W-1:0]       out_angle_value,
  input wire logic signed [mftt_pkg::TURN_W-1:0] out_turn_count
);

  // A result word that waits is held unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched)
      && $stable(out_motor_index) && $stable(out_speed_value)
      && $stable(out_angle_value) && $stable(out_turn_count))
    else $error("result word changed while stalled");

  // An unmatched frame carries an all-zero result.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_motor_index == '0 && out_speed_value == '0
      && out_angle_value == '0 && out_turn_count == '0)
    else $error("unmatched frame gave non-zero fields");

  // The input side only stalls when a result is held back by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motor_feedback_turn_tracker_core mftt_checker u_mftt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_matched     (out_matched),
  .out_motor_index (out_motor_index),
  .out_speed_value (out_speed_value),
  .out_angle_value (out_angle_value),
  .out_turn_count  (out_turn_count)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for motor_feedback_turn_tracker_core: directed and random frames
// against an in-bench model of the per-motor speed, angle and turn count.
// Depends on mftt_pkg and the core RTL only.

module testbench;

  localparam int MOTORS      = mftt_pkg::MOTOR_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;

  localparam int ID_W   = mftt_pkg::ID_W;
  localparam int BYTE_W = mftt_pkg::BYTE_W;
  localparam int WORD_W = mftt_pkg::WORD_W;
  localparam int TURN_W = mftt_pkg::TURN_W;
  localparam int MIDX_W = mftt_pkg::MIDX_W;
  localparam int CFG_DW = mftt_pkg::CFG_DW;
  localparam int CFG_IW = mftt_pkg::CFG_IW;
  localparam int HI_W   = CFG_DW - ID_W;

  typedef struct packed {
    logic              matched;
    logic [MIDX_W-1:0] motor_index;
    logic [WORD_W-1:0] speed_value;
    logic [WORD_W-1:0] angle_value;
    logic [TURN_W-1:0] turn_count;
  } feedback_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IW-1:0]        cfg_index;
  logic [CFG_DW-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [ID_W-1:0]          in_frame_identifier;
  logic [BYTE_W-1:0]        in_payload_byte0;
  logic [BYTE_W-1:0]        in_payload_byte1;
  logic [BYTE_W-1:0]        in_payload_byte2;
  logic [BYTE_W-1:0]        in_payload_byte3;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_matched;
  logic [MIDX_W-1:0]        out_motor_index;
  logic signed [WORD_W-1:0] out_speed_value;
  logic [WORD_W-1:0]        out_angle_value;
  logic signed [TURN_W-1:0] out_turn_count;

  logic [ID_W-1:0]   mdl_base_id;
  logic [WORD_W-1:0] mdl_threshold;
  logic [WORD_W-1:0] mdl_speed [MOTORS];
  logic [WORD_W-1:0] mdl_angle [MOTORS];
  logic [TURN_W-1:0] mdl_turns [MOTORS];

  feedback_t expected_feedback [$];

  int  fail_count;
  int  cycle_count;
  int  frames_sent;
  int  tracked_frames;
  int  cfg_writes;
  bit  idle_on;
  bit  hold_req;

  motor_feedback_turn_tracker_core #(
    .MOTOR_COUNT(MOTORS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_identifier(in_frame_identifier),
    .in_payload_byte0   (in_payload_byte0),
    .in_payload_byte1   (in_payload_byte1),
    .in_payload_byte2   (in_payload_byte2),
    .in_payload_byte3   (in_payload_byte3),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_matched        (out_matched),
    .out_motor_index    (out_motor_index),
    .out_speed_value    (out_speed_value),
    .out_angle_value    (out_angle_value),
    .out_turn_count     (out_turn_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_motor_model();
    mdl_base_id   = mftt_pkg::BASE_ID_RST;
    mdl_threshold = mftt_pkg::WRAP_THR_RST;
    for (int i = 0; i < MOTORS; i++) begin
      mdl_speed[i] = '0;
      mdl_angle[i] = '0;
      mdl_turns[i] = '0;
    end
  endfunction

  function automatic feedback_t track_frame(mftt_pkg::in_word_t w);
    feedback_t         fb;
    int                offset;
    int                diff;
    logic [WORD_W-1:0] angle;
    fb     = '0;
    offset = int'(w.frame_identifier) - int'(mdl_base_id);
    if (offset < 0 || offset >= MOTORS) begin
      return fb;
    end
    angle             = {w.payload_byte0, w.payload_byte1};
    mdl_speed[offset] = {w.payload_byte2, w.payload_byte3};
    diff              = int'(mdl_angle[offset]) - int'(angle);
    if (diff > int'(mdl_threshold)) begin
      mdl_turns[offset] = mdl_turns[offset] + TURN_W'(1);
    end else if (diff < -int'(mdl_threshold)) begin
      mdl_turns[offset] = mdl_turns[offset] - TURN_W'(1);
    end
    mdl_angle[offset] = angle;
    fb.matched        = 1'b1;
    fb.motor_index    = offset[MIDX_W-1:0];
    fb.speed_value    = mdl_speed[offset];
    fb.angle_value    = angle;
    fb.turn_count     = mdl_turns[offset];
    return fb;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic mftt_pkg::in_word_t make_frame(logic [ID_W-1:0] id,
                                                    logic [WORD_W-1:0] angle,
                                                    logic [WORD_W-1:0] speed);
    mftt_pkg::in_word_t w;
    w.frame_identifier = id;
    {w.payload_byte0, w.payload_byte1} = angle;
    {w.payload_byte2, w.payload_byte3} = speed;
    return w;
  endfunction

  // Mostly tracked-motor frames; angles step small or near the wrap threshold, or are random.
  function automatic mftt_pkg::in_word_t random_frame();
    int                pick;
    int                m;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] angle;
    logic [WORD_W-1:0] speed;
    pick = $urandom_range(0, 99);
    m    = $urandom_range(0, MOTORS - 1);
    if (pick < 75) begin
      id = ID_W'(int'(mdl_base_id) + m);
    end else if (pick < 88) begin
      if ($urandom_range(0, 1)) begin
        id = ID_W'(int'(mdl_base_id) - 1 - int'($urandom_range(0, 1)));
      end else begin
        id = ID_W'(int'(mdl_base_id) + MOTORS + int'($urandom_range(0, 1)));
      end
    end else begin
      id = ID_W'($urandom);
    end
    prev  = mdl_angle[m];
    delta = WORD_W'($urandom_range(0, 2));
    case ($urandom_range(0, 4))
      0: angle = WORD_W'($urandom);
      1: begin
        delta = WORD_W'($urandom_range(0, 2000));
        angle = prev + delta - 16'd1000;
      end
      2: angle = prev + mdl_threshold + delta - 16'd1;
      3: angle = prev - mdl_threshold + delta - 16'd1;
      default: angle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    speed = WORD_W'($urandom);
    if ($urandom_range(0, 9) == 0) speed = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    return make_frame(id, angle, speed);
  endfunction

  task automatic send_frame(mftt_pkg::in_word_t w);
    int        gap;
    feedback_t fb;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_frame_identifier <= w.frame_identifier;
    in_payload_byte0    <= w.payload_byte0;
    in_payload_byte1    <= w.payload_byte1;
    in_payload_byte2    <= w.payload_byte2;
    in_payload_byte3    <= w.payload_byte3;
    do @(posedge clk); while (!in_ready);
    fb = track_frame(w);
    expected_feedback.push_back(fb);
    frames_sent++;
    if (fb.matched) tracked_frames++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_feedback.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == mftt_pkg::CFG_IDX_BASE_ID) mdl_base_id = data[ID_W-1:0];
    else mdl_threshold = data;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_frame(make_frame(11'h201, 16'hFFFF, 16'h8000));
    send_frame(make_frame(11'h201, 16'h0000, 16'h7FFF));
    send_frame(make_frame(11'h201, 16'h1554, 16'h0001));
    send_frame(make_frame(11'h201, 16'h0000, 16'hFFFF));
    send_frame(make_frame(11'h201, 16'h1555, 16'h0100));
    send_frame(make_frame(11'h204, 16'hA5C3, 16'h5A3C));
    send_frame(make_frame(11'h202, 16'h0000, 16'h0000));
    send_frame(make_frame(11'h203, 16'h1234, 16'hFEDC));
    send_frame(make_frame(11'h200, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(11'h205, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(11'h000, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(11'h7FF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_threshold_extremes();
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_WRAP_THR, 16'd0);
    send_frame(make_frame(11'h201, 16'h1555, 16'h0002));
    send_frame(make_frame(11'h201, 16'h1554, 16'h0003));
    send_frame(make_frame(11'h201, 16'h1555, 16'h0004));
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_WRAP_THR, 16'hFFFF);
    send_frame(make_frame(11'h201, 16'hFFFF, 16'h0005));
    send_frame(make_frame(11'h201, 16'h0000, 16'h0006));
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_WRAP_THR, 16'hFFFE);
    send_frame(make_frame(11'h201, 16'hFFFF, 16'h0007));
    send_frame(make_frame(11'h201, 16'h0000, 16'h0008));
  endtask

  // Identifiers must not wrap past the top of the 11-bit range.
  task automatic test_window_edges();
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_BASE_ID, {5'b11111, 11'd0});
    write_register(mftt_pkg::CFG_IDX_WRAP_THR, mftt_pkg::WRAP_THR_RST);
    send_frame(make_frame(11'd0, 16'h8000, 16'hC001));
    send_frame(make_frame(11'd3, 16'h0001, 16'h3FFE));
    send_frame(make_frame(11'd4, 16'h0001, 16'h3FFE));
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_BASE_ID, 16'd2047);
    send_frame(make_frame(11'd2047, 16'hF000, 16'h0F0F));
    send_frame(make_frame(11'd0, 16'hF000, 16'h0F0F));
    send_frame(make_frame(11'd2046, 16'hF000, 16'h0F0F));
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_BASE_ID, 16'd2045);
    send_frame(make_frame(11'd2047, 16'h7FFF, 16'hF0F0));
  endtask

  task automatic test_random_traffic();
    logic [CFG_DW-1:0] base_sel;
    logic [CFG_DW-1:0] thr_sel;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          base_sel = CFG_DW'(mftt_pkg::BASE_ID_RST);
          thr_sel  = mftt_pkg::WRAP_THR_RST;
        end
        1: begin base_sel = 16'd2047;    thr_sel = 16'hFFFF; end
        2: begin base_sel = 16'd0;       thr_sel = 16'd0; end
        3: begin
          base_sel = CFG_DW'($urandom_range(0, 2047));
          thr_sel  = CFG_DW'($urandom);
        end
        4: begin base_sel = 16'd2044;    thr_sel = CFG_DW'($urandom_range(0, 3000)); end
        default: begin base_sel = CFG_DW'($urandom_range(0, 2047)); thr_sel = 16'h8000; end
      endcase
      base_sel[CFG_DW-1:ID_W] = HI_W'($urandom);
      wait_drain();
      write_register(mftt_pkg::CFG_IDX_BASE_ID, base_sel);
      write_register(mftt_pkg::CFG_IDX_WRAP_THR, thr_sel);
      idle_on = (phase != 0);
      repeat (85) send_frame(random_frame());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_register(mftt_pkg::CFG_IDX_BASE_ID, CFG_DW'(mftt_pkg::BASE_ID_RST));
    write_register(mftt_pkg::CFG_IDX_WRAP_THR, mftt_pkg::WRAP_THR_RST);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_frame(random_frame());
    wait_drain();
    idle_on = 1'b1;
    repeat (16) send_frame(random_frame());
  endtask

  initial begin : result_receiver
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    feedback_t fb;
    if (rst_n && out_valid && out_ready) begin
      if (expected_feedback.size() == 0) begin
        $error("result word arrived with no frame outstanding");
        fail_count++;
      end else begin
        fb = expected_feedback.pop_front();
        check_field("matched", 32'(fb.matched), 32'(out_matched));
        check_field("motor_index", 32'(fb.motor_index), 32'(out_motor_index));
        check_field("speed_value", 32'(fb.speed_value), 32'($unsigned(out_speed_value)));
        check_field("angle_value", 32'(fb.angle_value), 32'(out_angle_value));
        check_field("turn_count", fb.turn_count, $unsigned(out_turn_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL motor_feedback_turn_tracker_core");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = mftt_pkg::CFG_IDX_BASE_ID;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_frame_identifier = '0;
    in_payload_byte0    = '0;
    in_payload_byte1    = '0;
    in_payload_byte2    = '0;
    in_payload_byte3    = '0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    fail_count          = 0;
    cycle_count         = 0;
    frames_sent         = 0;
    tracked_frames      = 0;
    cfg_writes          = 0;
    reset_motor_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_threshold_extremes();
    test_window_edges();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d frames (%0d for tracked motors) across %0d register writes,",
             frames_sent, tracked_frames, cfg_writes);
    $display("including threshold and window extremes, a long result stall and a drain pause.");
    if (fail_count == 0) begin
      $display("PASS motor_feedback_turn_tracker_core");
    end else begin
      $display("FAIL motor_feedback_turn_tracker_core");
    end
    $finish;
  end

endmodule
